@@ hw/rtl/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked only outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked only outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked during reset too.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/bqhp_pkg.sv @@
package bqhp_pkg;

  localparam int SAMP_W         = 16;
  localparam int COEF_W         = 32;
  localparam int HIST_W         = 40;
  localparam int COUNT_W        = 4;
  localparam int CHAN_OUT_W     = 3;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int COEF_FRAC_BITS = 30;
  localparam int OUT_FRAC_BITS  = 16;

  // Feedback products are split so that no multiplier exceeds 32x25.
  localparam int HIST_LO_W = 24;
  localparam int HIST_HI_W = HIST_W - HIST_LO_W;

  // Exact accumulator: feedback products need 72 bits, two of them and the
  // shifted feedforward sum fit in 74.
  localparam int ACC_W = COEF_W + HIST_W + 2;
  localparam int FF_W  = COEF_W + SAMP_W + 2;

  typedef logic signed [SAMP_W-1:0]  sample_t;
  typedef logic signed [COEF_W-1:0]  coef_word_t;
  typedef logic signed [HIST_W-1:0]  hist_t;
  typedef logic [COUNT_W-1:0]        count_t;
  typedef logic [CHAN_OUT_W-1:0]     chan_t;
  typedef logic [CFG_ADDR_W-1:0]     cfg_addr_t;
  typedef logic [CFG_DATA_W-1:0]     cfg_data_t;

  localparam sample_t SAMP_MAX = sample_t'(16'sh7FFF);
  localparam sample_t SAMP_MIN = sample_t'(16'sh8000);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_B0    = 3'd0,
    REG_B1    = 3'd1,
    REG_B2    = 3'd2,
    REG_A1    = 3'd3,
    REG_A2    = 3'd4,
    REG_COUNT = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    coef_word_t b0;
    coef_word_t b1;
    coef_word_t b2;
    coef_word_t a1;
    coef_word_t a2;
  } coef_t;

  // Per-channel history as seen by the current sample.
  typedef struct packed {
    sample_t x1;
    sample_t x2;
    hist_t   y1;
    hist_t   y2;
  } hist_rd_t;

endpackage

@@ hw/rtl/bqhp_sample_if.sv @@
interface bqhp_sample_if;
  import bqhp_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_in;
  logic    start_of_block;

  modport source (output valid, output sample_in, output start_of_block, input ready);
  modport sink   (input valid, input sample_in, input start_of_block, output ready);
endinterface

@@ hw/rtl/bqhp_result_if.sv @@
interface bqhp_result_if;
  import bqhp_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_out;
  chan_t   channel_index;
  logic    clipped;

  modport source (output valid, output sample_out, output channel_index, output clipped,
                  input ready);
  modport sink   (input valid, input sample_out, input channel_index, input clipped,
                  output ready);
endinterface

@@ hw/rtl/bqhp_cfg_if.sv @@
interface bqhp_cfg_if;
  import bqhp_pkg::*;

  logic      valid;
  logic      ready;
  cfg_addr_t addr;
  cfg_data_t data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

@@ hw/rtl/bqhp_regs.sv @@
module bqhp_regs (
  input  logic            clk,
  input  logic            rst_n,
  bqhp_cfg_if.sink        cfg_bus,
  output bqhp_pkg::coef_t  coef,
  output bqhp_pkg::count_t chan_count
);
  import bqhp_pkg::*;

  coef_t  coef_r;
  count_t count_r;

  assign cfg_bus.ready = 1'b1;
  assign coef          = coef_r;
  assign chan_count    = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r  <= '0;
      count_r <= count_t'(1);
    end else if (cfg_bus.valid) begin
      case (cfg_bus.addr)
        REG_B0:    coef_r.b0 <= coef_word_t'(cfg_bus.data);
        REG_B1:    coef_r.b1 <= coef_word_t'(cfg_bus.data);
        REG_B2:    coef_r.b2 <= coef_word_t'(cfg_bus.data);
        REG_A1:    coef_r.a1 <= coef_word_t'(cfg_bus.data);
        REG_A2:    coef_r.a2 <= coef_word_t'(cfg_bus.data);
        REG_COUNT: count_r   <= cfg_bus.data[COUNT_W-1:0];
        default:   ;  // drop writes to unmapped indexes
      endcase
    end
  end
endmodule

@@ hw/rtl/bqhp_hist.sv @@
module bqhp_hist #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               upd,
  input  logic               sob,
  input  bqhp_pkg::sample_t  x,
  input  bqhp_pkg::hist_t    y,
  input  bqhp_pkg::count_t   chan_count,
  output bqhp_pkg::hist_rd_t rd,
  output bqhp_pkg::chan_t    chan
);
  import bqhp_pkg::*;

  localparam int PTR_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CMP_W = (PTR_W + 1 > COUNT_W) ? PTR_W + 1 : COUNT_W;

  logic [PTR_W-1:0] ptr_r, ptr_nxt;
  logic [PTR_W-1:0] cur;
  logic [CMP_W-1:0] cnt_raw, cnt_eff, cur_ext, inc_ext, ptr_ext;

  sample_t x1_r [MAX_CHANNELS];
  sample_t x2_r [MAX_CHANNELS];
  hist_t   y1_r [MAX_CHANNELS];
  hist_t   y2_r [MAX_CHANNELS];

  // Clamp the channel count to 1..MAX_CHANNELS.
  always_comb begin
    cnt_raw = CMP_W'(chan_count);
    if (cnt_raw == '0) begin
      cnt_eff = CMP_W'(1);
    end else if (cnt_raw > CMP_W'(MAX_CHANNELS)) begin
      cnt_eff = CMP_W'(MAX_CHANNELS);
    end else begin
      cnt_eff = cnt_raw;
    end
  end

  // Start of block restarts at channel 0; a pointer past the count wraps.
  always_comb begin
    ptr_ext = sob ? '0 : CMP_W'(ptr_r);
    if (ptr_ext >= cnt_eff) begin
      cur_ext = '0;
    end else begin
      cur_ext = ptr_ext;
    end
    cur     = cur_ext[PTR_W-1:0];
    inc_ext = cur_ext + CMP_W'(1);
    if (inc_ext >= cnt_eff) begin
      ptr_nxt = '0;
    end else begin
      ptr_nxt = inc_ext[PTR_W-1:0];
    end
  end

  assign chan = cur_ext[CHAN_OUT_W-1:0];

  always_comb begin
    if (sob) begin
      rd = '0;
    end else begin
      rd.x1 = x1_r[cur];
      rd.x2 = x2_r[cur];
      rd.y1 = y1_r[cur];
      rd.y2 = y2_r[cur];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        x1_r[c] <= '0;
        x2_r[c] <= '0;
        y1_r[c] <= '0;
        y2_r[c] <= '0;
      end
    end else if (upd) begin
      ptr_r <= ptr_nxt;
      // Shift the current channel's history; clear the others on start of block.
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        if (c == int'(cur)) begin
          x2_r[c] <= rd.x1;
          x1_r[c] <= x;
          y2_r[c] <= rd.y1;
          y1_r[c] <= y;
        end else if (sob) begin
          x1_r[c] <= '0;
          x2_r[c] <= '0;
          y1_r[c] <= '0;
          y2_r[c] <= '0;
        end
      end
    end
  end
endmodule

@@ hw/rtl/bqhp_datapath.sv @@
module bqhp_datapath (
  input  bqhp_pkg::coef_t    coef,
  input  bqhp_pkg::sample_t  x,
  input  bqhp_pkg::hist_rd_t rd,
  output bqhp_pkg::hist_t    y,
  output bqhp_pkg::sample_t  sample_out,
  output logic               clipped
);
  import bqhp_pkg::*;

  localparam int P_FF_W = COEF_W + SAMP_W;
  localparam int P_LO_W = COEF_W + HIST_LO_W + 1;
  localparam int P_HI_W = COEF_W + HIST_HI_W;
  localparam logic [HIST_W:0] TZ_BIAS = ((HIST_W + 1)'(1) << OUT_FRAC_BITS) - (HIST_W + 1)'(1);

  logic signed [P_FF_W-1:0]   p_b0, p_b1, p_b2;
  logic signed [FF_W-1:0]     ff;
  logic signed [HIST_LO_W:0]  y1_lo, y2_lo;
  logic signed [HIST_HI_W-1:0] y1_hi, y2_hi;
  logic signed [P_LO_W-1:0]   p_a1_lo, p_a2_lo;
  logic signed [P_HI_W-1:0]   p_a1_hi, p_a2_hi;
  logic signed [ACC_W-1:0]    fb1, fb2, acc, acc_sh;
  logic signed [HIST_W:0]     y_ext, y_tz, q;
  logic [HIST_W:0]            bias;
  logic                       hist_ovf;
  logic                       out_ovf;

  // Feedforward: three exact 32x16 products.
  assign p_b0 = coef.b0 * x;
  assign p_b1 = coef.b1 * rd.x1;
  assign p_b2 = coef.b2 * rd.x2;
  assign ff   = FF_W'(p_b0) + FF_W'(p_b1) + FF_W'(p_b2);

  // Feedback: split each 40-bit history into a signed high and unsigned low part.
  assign y1_lo = $signed({1'b0, rd.y1[HIST_LO_W-1:0]});
  assign y2_lo = $signed({1'b0, rd.y2[HIST_LO_W-1:0]});
  assign y1_hi = rd.y1[HIST_W-1:HIST_LO_W];
  assign y2_hi = rd.y2[HIST_W-1:HIST_LO_W];

  assign p_a1_lo = coef.a1 * y1_lo;
  assign p_a1_hi = coef.a1 * y1_hi;
  assign p_a2_lo = coef.a2 * y2_lo;
  assign p_a2_hi = coef.a2 * y2_hi;

  assign fb1 = (ACC_W'(p_a1_hi) <<< HIST_LO_W) + ACC_W'(p_a1_lo);
  assign fb2 = (ACC_W'(p_a2_hi) <<< HIST_LO_W) + ACC_W'(p_a2_lo);

  assign acc    = (ACC_W'(ff) <<< OUT_FRAC_BITS) - fb1 - fb2;
  assign acc_sh = acc >>> COEF_FRAC_BITS;

  // Saturate the new history to 40 bits.
  assign hist_ovf = (acc_sh[ACC_W-1:HIST_W-1] != '0) && (acc_sh[ACC_W-1:HIST_W-1] != '1);

  always_comb begin
    if (hist_ovf) begin
      y = acc_sh[ACC_W-1] ? {1'b1, {(HIST_W-1){1'b0}}} : {1'b0, {(HIST_W-1){1'b1}}};
    end else begin
      y = acc_sh[HIST_W-1:0];
    end
  end

  // Drop the fraction toward zero: bias negative values before the shift.
  assign y_ext = $signed({y[HIST_W-1], y});
  assign bias  = y[HIST_W-1] ? TZ_BIAS : '0;
  assign y_tz  = y_ext + $signed(bias);
  assign q     = y_tz >>> OUT_FRAC_BITS;

  assign out_ovf = (q[HIST_W:SAMP_W-1] != '0) && (q[HIST_W:SAMP_W-1] != '1);

  always_comb begin
    if (out_ovf) begin
      sample_out = q[HIST_W] ? SAMP_MIN : SAMP_MAX;
    end else begin
      sample_out = q[SAMP_W-1:0];
    end
  end

  assign clipped = out_ovf;
endmodule

@@ hw/rtl/biquad_highpass_multichannel_top.sv @@
// Multichannel biquad (direct form 1) filter for interleaved 16-bit audio.
//
// in_bus  : one sample per beat; start_of_block clears every channel history
//           and restarts the channel rotation at channel 0 before this sample.
// out_bus : one filtered sample per input beat, tagged with its channel and a
//           clipped flag when the result was saturated to 16 bits.
// cfg_bus : register writes (b0, b1, b2, a1, a2 as Q2.30, then channel count);
//           always ready. Write only while no sample is in flight.
//
// Path: each input beat goes into the input register, then through one
// combinational filter pass into the output register.
// Throughput: one sample per cycle unless out_bus stalls; the per-channel
// feedback closes in a single pass; a one-channel stream runs at full rate.
// Stall: when out_bus.ready is low the output register holds its beat; the
// input register keeps accepting until it is also full, then in_bus.ready
// drops. Nothing is lost or repeated.
// Reset (synchronous, active low): coefficients zero, channel count one,
// histories and channel pointer zero, both pipeline registers empty.
module biquad_highpass_multichannel_top #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  bqhp_sample_if.sink   in_bus,
  bqhp_result_if.source out_bus,
  bqhp_cfg_if.sink      cfg_bus
);
  import bqhp_pkg::*;

  // Input register
  logic    s1_valid_r;
  sample_t s1_x_r;
  logic    s1_sob_r;

  // Output register
  logic    out_valid_r;
  sample_t out_sample_r;
  chan_t   out_chan_r;
  logic    out_clip_r;

  logic     adv;
  coef_t    coef;
  count_t   chan_count;
  hist_rd_t rd;
  chan_t    chan;
  hist_t    y_new;
  sample_t  y_sample;
  logic     y_clip;

  // Advance a valid input register into the output register whenever the
  // output is empty or being drained this cycle.
  assign adv          = s1_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready = !s1_valid_r || adv;

  bqhp_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_bus    (cfg_bus),
    .coef       (coef),
    .chan_count (chan_count)
  );

  // Per-channel history and channel rotation; updated only on advance.
  bqhp_hist #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_hist (
    .clk        (clk),
    .rst_n      (rst_n),
    .upd        (adv),
    .sob        (s1_sob_r),
    .x          (s1_x_r),
    .y          (y_new),
    .chan_count (chan_count),
    .rd         (rd),
    .chan       (chan)
  );

  // Five products, exact sum, rescale and saturate.
  bqhp_datapath u_dp (
    .coef       (coef),
    .x          (s1_x_r),
    .rd         (rd),
    .y          (y_new),
    .sample_out (y_sample),
    .clipped    (y_clip)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      s1_valid_r <= in_bus.valid;
    end
  end

  // Payload needs no reset; load on each accepted beat.
  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      s1_x_r   <= in_bus.sample_in;
      s1_sob_r <= in_bus.start_of_block;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_sample_r <= y_sample;
      out_chan_r   <= chan;
      out_clip_r   <= y_clip;
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.sample_out    = out_sample_r;
  assign out_bus.channel_index = out_chan_r;
  assign out_bus.clipped       = out_clip_r;
endmodule

@@ hw/rtl/bqhp_checker.sv @@
`include "assert_macros.svh"

module bqhp_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input bqhp_pkg::sample_t sample_out,
  input bqhp_pkg::chan_t   channel_index,
  input logic              clipped
);
  import bqhp_pkg::*;

  // A stalled result beat stays and keeps its payload.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(sample_out) && $stable(channel_index) && $stable(clipped))

  // Reset empties the output register.
  `ASSERT_NEXT_ALWAYS(a_rst_empty, clk, !rst_n, !out_valid)

  // A clipped sample sits on one of the rails.
  `ASSERT_IMPLY(a_clip_rail, clk, rst_n, out_valid && clipped,
    sample_out == SAMP_MAX || sample_out == SAMP_MIN)
endmodule

bind biquad_highpass_multichannel_top bqhp_checker u_bqhp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_bus.valid),
  .out_ready     (out_bus.ready),
  .sample_out    (out_bus.sample_out),
  .channel_index (out_bus.channel_index),
  .clipped       (out_bus.clipped)
);
